>>> rtl/mcsm_pkg.sv
// Shared types and constants of the multichannel sample mixer.
`timescale 1ns / 1ps

package mcsm_pkg;

    localparam int LEN_W     = 17;  // sound and channel length in bytes
    localparam int BYTE_W    = 8;   // one unsigned sample byte
    localparam int OUT_W     = 16;  // mixed output sample
    localparam int CNT_OUT_W = 4;   // playing channel count on the result
    localparam int CHCFG_W   = 4;   // active channel count register
    localparam int SNDCFG_W  = 5;   // sound count register
    localparam int SIDX_W    = 4;   // sound index field
    localparam int CHN_W     = 3;   // channel number field

    // Midscale of an unsigned sample, which is also the silent level.
    localparam logic [BYTE_W-1:0] SILENCE     = 8'd128;
    localparam logic [BYTE_W-1:0] FULL_SCALE  = 8'd255;
    // 128 * 257: maps 1..255 into the signed 16-bit range; 0 wraps.
    localparam logic [OUT_W-1:0]  WIDE_OFFSET = 16'h8080;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_DEFINE = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef struct packed {
        logic rd_en;    // read one channel entry for a tick step
        logic load_en;  // load a channel entry from a sound
    } chan_ctl_t;

    typedef struct packed {
        logic smp_wr;   // write one sample byte
        logic clear;    // start a new mix
    } mix_ctl_t;

endpackage

>>> rtl/mcsm_sound_table.sv
// Sound table memory with per-entry defined bits and a registered read port.
`timescale 1ns / 1ps

module mcsm_sound_table import mcsm_pkg::*;
#(
    parameter int NSND = 16,
    parameter int AW   = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SIDX_W-1:0] wr_idx,
    input  logic [AW-1:0]     wr_start,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic              wr_loops,
    input  logic              rd_en,
    input  logic [SIDX_W-1:0] rd_idx,
    output logic [AW-1:0]     rd_start,
    output logic [LEN_W-1:0]  rd_len,
    output logic              rd_loops,
    output logic              rd_defined
);

    localparam int SIW    = (NSND > 1) ? $clog2(NSND) : 1;
    localparam int WORD_W = AW + LEN_W + 1;
    localparam logic [SIDX_W:0] DEPTH_LIM = (SIDX_W + 1)'(NSND);

    logic [WORD_W-1:0] mem [NSND];
    logic [WORD_W-1:0] rd_word_reg;
    logic [NSND-1:0]   defined_reg;
    logic              rd_def_reg;
    logic              wr_hit;
    logic              rd_hit;

    // Indexes beyond the table are dropped on a define and read as undefined.
    assign wr_hit = wr_en && ({1'b0, wr_idx} < DEPTH_LIM);
    assign rd_hit = {1'b0, rd_idx} < DEPTH_LIM;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_idx[SIW-1:0]] <= {wr_start, wr_len, wr_loops};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx[SIW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defined_reg <= '0;
            rd_def_reg  <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                defined_reg[wr_idx[SIW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_def_reg <= rd_hit && defined_reg[rd_idx[SIW-1:0]];
            end
        end
    end

    assign {rd_start, rd_len, rd_loops} = rd_word_reg;
    assign rd_defined = rd_def_reg;

endmodule

>>> rtl/mcsm_chan_table.sv
// Channel state memory with read-modify-write playback stepping.
`timescale 1ns / 1ps

module mcsm_chan_table import mcsm_pkg::*;
#(
    parameter int NCH = 8,
    parameter int AW  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  chan_ctl_t              ctl,
    input  logic [$clog2(NCH)-1:0] rd_idx,
    input  logic [$clog2(NCH)-1:0] load_idx,
    input  logic [AW-1:0]          load_start,
    input  logic [LEN_W-1:0]       load_len,
    input  logic                   load_loops,
    output logic                   play,
    output logic [AW-1:0]          smp_addr
);

    localparam int CW = $clog2(NCH);

    typedef struct packed {
        logic [AW-1:0]    start;
        logic [AW-1:0]    pos;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rem;
        logic             loops;
    } chan_word_t;

    chan_word_t     mem [NCH];
    chan_word_t     rd_word_reg;
    logic [NCH-1:0] valid_reg;
    logic           rd_valid_reg;
    logic           step_vld_reg;
    logic [CW-1:0]  step_idx_reg;

    chan_word_t     cur;
    chan_word_t     next_word;
    chan_word_t     wr_word;
    logic           loop_ch0;
    logic           reload;
    logic           playing;
    logic [AW-1:0]  eff_pos;
    logic [LEN_W-1:0] eff_rem;
    logic           wr_en;
    logic [CW-1:0]  wr_idx;

    always_comb
    begin
        // An entry never written reads as the all-zero reset entry.
        cur      = rd_valid_reg ? rd_word_reg : '0;
        // Only channel 0 honors the loop flag.
        loop_ch0 = (step_idx_reg == '0) && cur.loops;
        reload   = loop_ch0 && (cur.len != '0) && (cur.rem == '0);
        playing  = loop_ch0 ? (cur.len != '0) : (cur.rem != '0);
        eff_pos  = reload ? cur.start : cur.pos;
        eff_rem  = reload ? cur.len : cur.rem;

        next_word       = cur;
        next_word.pos   = eff_pos + AW'(1);
        next_word.rem   = eff_rem - LEN_W'(1);

        if (ctl.load_en)
        begin
            wr_en         = 1'b1;
            wr_idx        = load_idx;
            wr_word.start = load_start;
            wr_word.pos   = load_start;
            wr_word.len   = load_len;
            wr_word.rem   = load_len;
            wr_word.loops = load_loops;
        end
        else
        begin
            wr_en   = step_vld_reg && playing;
            wr_idx  = step_idx_reg;
            wr_word = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            rd_word_reg  <= mem[rd_idx];
            step_idx_reg <= rd_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            step_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
            step_vld_reg <= ctl.rd_en;
        end
    end

    assign play     = step_vld_reg && playing;
    assign smp_addr = eff_pos;

    // A start load and a tick write-back share the write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load_en && step_vld_reg))
        else $error("channel load collides with a tick write-back");

    // The write-back of one channel must never hit the entry being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_vld_reg && playing && ctl.rd_en) |-> (rd_idx != step_idx_reg))
        else $error("channel write-back overlaps a read of the same entry");

endmodule

>>> rtl/mcsm_mixer.sv
// Sample memory, mix accumulator, clipping and output formatting.
`timescale 1ns / 1ps

module mcsm_mixer import mcsm_pkg::*;
#(
    parameter int NCH   = 8,
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mix_ctl_t                ctl,
    input  logic [AW-1:0]           wr_addr,
    input  logic [BYTE_W-1:0]       wr_byte,
    input  logic                    wide,
    input  logic                    play,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [OUT_W-1:0] mix_sample,
    output logic [CNT_OUT_W-1:0]    mix_count
);

    localparam int CNT_W = $clog2(NCH + 1);
    localparam int ACC_W = CNT_W + 8;
    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(SILENCE);
    localparam logic signed [ACC_W-1:0] ACC_FULL = ACC_W'(FULL_SCALE);

    logic [BYTE_W-1:0]       mem [DEPTH];
    logic [BYTE_W-1:0]       byte_reg;
    logic                    smp_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic [BYTE_W-1:0]       centered;
    logic signed [ACC_W-1:0] delta;
    logic [BYTE_W-1:0]       clipped;
    logic [OUT_W-1:0]        wide_val;

    always_ff @(posedge clk)
    begin
        if (ctl.smp_wr)
        begin
            mem[wr_addr] <= wr_byte;
        end
        if (play)
        begin
            byte_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= 1'b0;
        end
        else
        begin
            smp_vld_reg <= play;
        end
    end

    // Flipping the top bit turns an unsigned byte into byte minus 128.
    assign centered = byte_reg ^ SILENCE;
    assign delta    = $signed({{(ACC_W - BYTE_W){centered[BYTE_W-1]}}, centered});

    // The mix starts at the silent level; channel 0 then counts like any other.
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= ACC_INIT;
            cnt_reg <= '0;
        end
        else if (smp_vld_reg)
        begin
            acc_reg <= acc_reg + delta;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            clipped = '0;
        end
        else if (acc_reg > ACC_FULL)
        begin
            clipped = FULL_SCALE;
        end
        else
        begin
            clipped = acc_reg[BYTE_W-1:0];
        end
        wide_val   = {clipped, clipped} - WIDE_OFFSET;
        mix_sample = wide ? $signed(wide_val) : $signed({8'h00, clipped});
    end

    assign mix_count = CNT_OUT_W'(cnt_reg);

endmodule

>>> rtl/multichannel_sample_mixer.sv
// Top level of the multichannel sample mixer: configuration, sequencing, result word.
`timescale 1ns / 1ps

// Wavetable mixer for unsigned 8-bit samples. Each input word is one of four
// commands: write a sample byte, define a sound, start a sound on a channel, or
// tick. Every input word produces exactly one result word. A write or define
// goes from idle to the result state, a start passes a start check first, and
// a tick reads the channel state memory once per cycle, one channel at a time,
// for N channels, N being the effective channel count (the configured count held
// to 2..MAX_CHANNELS). Each entry read is registered, its sample byte is then
// fetched into a register and summed. The next input word is taken
// as soon as the sequencer is back in idle, while the previous result may still
// be waiting in the output register. Channel 0 supplies the base level (its byte,
// or 128 when silent) and is the only channel that loops; every other playing
// channel adds its byte minus 128, and the sum is clipped to 0..255, optionally
// expanded to signed 16 bits as v * 257 - 32896. The sample memory is not cleared
// at reset and must be written before it is played; the sound and channel tables
// reset to empty through per-entry valid bits, so no clearing pass is needed.
// SAMPLE_MEM_DEPTH must be a power of two, since addresses wrap by truncation.
// Configuration writes are accepted every cycle and must only be issued while the
// block is idle.

module multichannel_sample_mixer import mcsm_pkg::*;
#(
    parameter int MAX_CHANNELS     = 8,
    parameter int MAX_SOUNDS       = 16,
    parameter int SAMPLE_MEM_DEPTH = 65536
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              func,
    input  logic [15:0]             mem_address,
    input  logic [BYTE_W-1:0]       byte_value,
    input  logic [SIDX_W-1:0]       sound_index,
    input  logic [LEN_W-1:0]        sound_length,
    input  logic                    loop_flag,
    input  logic [CHN_W-1:0]        channel_number,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] mixed_sample,
    output logic [CNT_OUT_W-1:0]    playing_count,
    output logic                    status,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [SNDCFG_W-1:0]     cfg_data
);

    localparam int AW   = $clog2(SAMPLE_MEM_DEPTH);
    localparam int CW   = $clog2(MAX_CHANNELS);
    // Only sound indexes that the sound_index field can name are ever stored.
    localparam int NSND = (MAX_SOUNDS < (1 << SIDX_W)) ? MAX_SOUNDS : (1 << SIDX_W);

    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_WIDE     = 2'd1;
    localparam logic [1:0] CFG_SOUNDS   = 2'd2;

    localparam logic [CHCFG_W:0] CH_MIN = (CHCFG_W + 1)'(2);
    localparam logic [CHCFG_W:0] CH_MAX = (CHCFG_W + 1)'(MAX_CHANNELS);
    localparam logic [CHCFG_W-1:0] CH_RESET = CHCFG_W'(6);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_CHK,
        ST_TICK_READ,
        ST_TICK_DRAIN,
        ST_TICK_LAST,
        ST_RESULT
    } state_t;

    // Configuration registers.
    logic [CHCFG_W-1:0]  chan_cfg_reg;
    logic                wide_reg;
    logic [SNDCFG_W-1:0] snd_cnt_reg;
    logic [CHCFG_W:0]    neff;

    // Sequencer state and the result word.
    state_t                  state_reg, state_next;
    logic [CW-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                    stat_reg, stat_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_mixed_reg, out_mixed_next;
    logic [CNT_OUT_W-1:0]    out_count_reg, out_count_next;
    logic                    out_status_reg, out_status_next;

    // Fields of the word in progress that are needed after acceptance.
    func_t             func_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [CHN_W-1:0]  chn_reg;

    logic              in_accept;
    func_t             in_func;
    logic              res_load;
    logic              last_read;
    logic              start_ok;

    logic [AW-1:0]     snd_start;
    logic [LEN_W-1:0]  snd_len;
    logic              snd_loops;
    logic              snd_defined;

    chan_ctl_t         chan_ctl;
    mix_ctl_t          mix_ctl;
    logic              play;
    logic [AW-1:0]     smp_addr;
    logic signed [OUT_W-1:0]  mix_sample;
    logic [CNT_OUT_W-1:0]     mix_count;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_func   = func_t'(func);
    assign cfg_ready = 1'b1;

    // Configuration port. Indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg <= CH_RESET;
            wide_reg     <= 1'b0;
            snd_cnt_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNELS: chan_cfg_reg <= cfg_data[CHCFG_W-1:0];
                CFG_WIDE:     wide_reg     <= cfg_data[0];
                CFG_SOUNDS:   snd_cnt_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // The configured channel count is held to 2..MAX_CHANNELS.
    always_comb
    begin
        neff = {1'b0, chan_cfg_reg};
        if (neff < CH_MIN)
        begin
            neff = CH_MIN;
        end
        else if (neff > CH_MAX)
        begin
            neff = CH_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= in_func;
            sidx_reg <= sound_index;
            chn_reg  <= channel_number;
        end
    end

    // A start is rejected when the sound is past the sound count, the channel
    // is past the channel count, or the sound was never defined.
    assign start_ok = ({1'b0, sidx_reg} < snd_cnt_reg) && snd_defined
                      && ({2'b00, chn_reg} < neff);

    assign last_read = ((CHCFG_W + 1)'(rd_cnt_reg) == (neff - (CHCFG_W + 1)'(1)));
    assign res_load  = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    // Memory commands. Byte writes and sound definitions complete at the
    // acceptance edge; the sound table read for a start is issued there too,
    // and a tick clears the accumulator there.
    always_comb
    begin
        mix_ctl.smp_wr   = in_accept && (in_func == FUNC_WRITE);
        mix_ctl.clear    = in_accept && (in_func == FUNC_TICK);
        chan_ctl.rd_en   = (state_reg == ST_TICK_READ);
        chan_ctl.load_en = (state_reg == ST_START_CHK) && start_ok;
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg;
        out_mixed_next  = out_mixed_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    stat_next   = 1'b0;
                    rd_cnt_next = '0;
                    case (in_func)
                        FUNC_START: state_next = ST_START_CHK;
                        FUNC_TICK:  state_next = ST_TICK_READ;
                        default:    state_next = ST_RESULT;
                    endcase
                end
            end
            ST_START_CHK:
            begin
                stat_next  = !start_ok;
                state_next = ST_RESULT;
            end
            ST_TICK_READ:
            begin
                // One channel entry is read per cycle.
                if (last_read)
                begin
                    state_next = ST_TICK_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
            end
            ST_TICK_DRAIN:
            begin
                // The last channel is stepped and its byte fetched.
                state_next = ST_TICK_LAST;
            end
            ST_TICK_LAST:
            begin
                // The last byte enters the accumulator.
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_load)
                begin
                    out_valid_next  = 1'b1;
                    out_mixed_next  = (func_reg == FUNC_TICK) ? mix_sample : '0;
                    out_count_next  = (func_reg == FUNC_TICK) ? mix_count : '0;
                    out_status_next = stat_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            stat_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_mixed_reg  <= '0;
            out_count_reg  <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            stat_reg       <= stat_next;
            out_valid_reg  <= out_valid_next;
            out_mixed_reg  <= out_mixed_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mixed_sample  = out_mixed_reg;
    assign playing_count = out_count_reg;
    assign status        = out_status_reg;

    mcsm_sound_table #(
        .NSND (NSND),
        .AW   (AW)
    ) u_sound_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_accept && (in_func == FUNC_DEFINE)),
        .wr_idx     (sound_index),
        .wr_start   (AW'(mem_address)),
        .wr_len     (sound_length),
        .wr_loops   (loop_flag),
        .rd_en      (in_accept && (in_func == FUNC_START)),
        .rd_idx     (sound_index),
        .rd_start   (snd_start),
        .rd_len     (snd_len),
        .rd_loops   (snd_loops),
        .rd_defined (snd_defined)
    );

    mcsm_chan_table #(
        .NCH (MAX_CHANNELS),
        .AW  (AW)
    ) u_chan_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (chan_ctl),
        .rd_idx     (rd_cnt_reg),
        .load_idx   (CW'(chn_reg)),
        .load_start (snd_start),
        .load_len   (snd_len),
        .load_loops (snd_loops),
        .play       (play),
        .smp_addr   (smp_addr)
    );

    mcsm_mixer #(
        .NCH   (MAX_CHANNELS),
        .DEPTH (SAMPLE_MEM_DEPTH),
        .AW    (AW)
    ) u_mixer (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mix_ctl),
        .wr_addr    (AW'(mem_address)),
        .wr_byte    (byte_value),
        .wide       (wide_reg),
        .play       (play),
        .rd_addr    (smp_addr),
        .mix_sample (mix_sample),
        .mix_count  (mix_count)
    );

    // Words are processed one at a time: no second word right behind a first.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("input word accepted while another is in progress");

    // A finished tick never counts more playing channels than are mixed.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && (func_reg == FUNC_TICK))
            |-> ({1'b0, mix_count} <= neff))
        else $error("playing count exceeds the channel count");

    // Only a start can come back rejected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && stat_reg) |-> (func_reg == FUNC_START))
        else $error("reject status on a word that is not a start");

endmodule
